### src/mcpp_pkg.sv
// Shared constants, types and helper functions for the corner pair projector.
// No dependencies; every other file depends on this package.
package mcpp_pkg;

   localparam int COORD_FRAC_BITS = 16;
   localparam int ROT_FRAC        = 14;
   localparam int COEF_FRAC       = 12;
   localparam int NORM_FRAC       = 20;

   localparam int COORD_W = 32;
   localparam int PIX_W   = 32;

   localparam int CAM_W   = 52;
   localparam int REM_W   = CAM_W + 2;
   localparam int QUOT_W  = NORM_FRAC + 2;
   localparam int NORM_W  = QUOT_W + 1;
   localparam int SQ_W    = 24;
   localparam int R2_W    = SQ_W + 1;
   localparam int TAN_W   = R2_W + 1;
   localparam int R4_W    = 28;
   localparam int R6_W    = 31;
   localparam int DIST_W  = 36;
   localparam int DIS_W   = 40;
   localparam int MA_W    = 36;
   localparam int MB_W    = 34;
   localparam int PROD_W  = MA_W + MB_W;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_X      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_Y      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_Z      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIAL     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TANGENTIAL = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FOCAL      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PRINCIPAL  = 3'd6;

   typedef struct packed {
      logic                     done;
      logic signed [NORM_W-1:0] quot;
   } mcpp_div_status_type;

   function automatic logic signed [PIX_W-1:0] sat_pix(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] hi;
      logic signed [PROD_W-1:0] lo;
      hi = PROD_W'($signed({1'b0, {(PIX_W-1){1'b1}}}));
      lo = PROD_W'($signed({1'b1, {(PIX_W-1){1'b0}}}));
      if (v > hi) return hi[PIX_W-1:0];
      if (v < lo) return lo[PIX_W-1:0];
      return v[PIX_W-1:0];
   endfunction

   function automatic logic signed [PIX_W-1:0] clamp_dis(input logic signed [DIS_W-1:0] v);
      logic signed [DIS_W-1:0] hi;
      logic signed [DIS_W-1:0] lo;
      hi = DIS_W'($signed({1'b0, {(PIX_W-1){1'b1}}}));
      lo = DIS_W'($signed({1'b1, {(PIX_W-1){1'b0}}}));
      if (v > hi) return hi[PIX_W-1:0];
      if (v < lo) return lo[PIX_W-1:0];
      return v[PIX_W-1:0];
   endfunction

endpackage

### src/mcpp_req_if.sv
// Input channel: one tracker-frame corner point per item.
// Depends on mcpp_pkg.
interface mcpp_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [mcpp_pkg::COORD_W-1:0] point_x;
   logic signed [mcpp_pkg::COORD_W-1:0] point_y;
   logic signed [mcpp_pkg::COORD_W-1:0] point_z;
   logic                                end_of_set;
   modport source (output valid, point_x, point_y, point_z, end_of_set, input ready);
   modport sink   (input valid, point_x, point_y, point_z, end_of_set, output ready);
endinterface

### src/mcpp_rsp_if.sv
// Result channel: one projected pixel per item.
// Depends on mcpp_pkg.
interface mcpp_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [mcpp_pkg::PIX_W-1:0] pixel_u;
   logic signed [mcpp_pkg::PIX_W-1:0] pixel_v;
   logic                              last_of_pair;
   modport source (output valid, pixel_u, pixel_v, last_of_pair, input ready);
   modport sink   (input valid, pixel_u, pixel_v, last_of_pair, output ready);
endinterface

### src/mcpp_mul.sv
// Shared signed multiplier with registered product.
// Depends on mcpp_pkg.
module mcpp_mul (
   input  logic                               clock,
   input  logic signed [mcpp_pkg::MA_W-1:0]   a,
   input  logic signed [mcpp_pkg::MB_W-1:0]   b,
   output logic signed [mcpp_pkg::PROD_W-1:0] prod_ff
);
   import mcpp_pkg::*;

   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(a) * PROD_W'(b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end
endmodule

### src/mcpp_div.sv
// Restoring divider, one quotient bit per cycle, quotient limited to +-2.0.
// Depends on mcpp_pkg.
module mcpp_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [mcpp_pkg::CAM_W-1:0] num,
   input  logic signed [mcpp_pkg::CAM_W-1:0] den,
   output mcpp_pkg::mcpp_div_status_type     status
);
   import mcpp_pkg::*;

   logic                     busy_ff, busy_in;
   logic                     init_ff, init_in;
   logic                     done_ff, done_in;
   logic [4:0]               cnt_ff, cnt_in;
   logic [REM_W-1:0]         rem_ff, rem_in;
   logic [CAM_W-1:0]         den_ff, den_in;
   logic [QUOT_W-1:0]        q_ff, q_in;
   logic                     neg_ff, neg_in;
   logic signed [NORM_W-1:0] quot_ff, quot_in;
   logic signed [CAM_W-1:0]  abs_num;
   logic [REM_W-1:0]         den_ext, den2, rem_sh;

   always_comb begin
      abs_num = num[CAM_W-1] ? -num : num;
      den_ext = REM_W'(den_ff);
      den2    = den_ext << 1;
      rem_sh  = rem_ff << 1;
      busy_in = busy_ff;
      init_in = init_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      neg_in  = neg_ff;
      quot_in = quot_ff;
      if (start) begin
         rem_in  = REM_W'($unsigned(abs_num));
         den_in  = den;
         neg_in  = num[CAM_W-1];
         q_in    = '0;
         cnt_in  = '0;
         init_in = 1'b1;
         busy_in = 1'b1;
      end else if (busy_ff && init_ff) begin
         init_in = 1'b0;
         if (rem_ff >= den2) begin
            q_in    = QUOT_W'(2) << NORM_FRAC;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else if (rem_ff >= den_ext) begin
            q_in   = QUOT_W'(1);
            rem_in = rem_ff - den_ext;
         end
      end else if (busy_ff) begin
         if (rem_sh >= den_ext) begin
            rem_in = rem_sh - den_ext;
            q_in   = {q_ff[QUOT_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            q_in   = {q_ff[QUOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(NORM_FRAC - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      if (done_in) begin
         quot_in = neg_ff ? -$signed(NORM_W'(q_in)) : $signed(NORM_W'(q_in));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         init_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         init_ff <= init_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      q_ff    <= q_in;
      neg_ff  <= neg_in;
      quot_ff <= quot_in;
   end

   assign status.done = done_ff;
   assign status.quot = quot_ff;
endmodule

### src/marker_corner_pair_projector.sv
// Top level: sequencer around the shared multiplier and divider, CSRs, pairing, output.
// Depends on mcpp_pkg, mcpp_req_if, mcpp_rsp_if, mcpp_mul, mcpp_div.
//
//   channel | dir | payload                             | handshake
//   req     | in  | point_x, point_y, point_z, end_of_set | valid/ready
//   rsp     | out | pixel_u, pixel_v, last_of_pair       | valid/ready
//   csr     | in  | csr_index, csr_write_data           | csr_write_enable
//
// Each point in front of the camera runs through the accepting idle cycle, 25
// multiplies through the one multiplier, two divides (a divide whose quotient
// saturates ends early), a depth check and a finish cycle; a point at depth
// <= 1 m skips the divides and all later multiplies. req.ready is high only while idle.
// Up to two results wait in the output buffer while the next point runs;
// every point holds in its finish cycle until that buffer has drained.
// Reset is synchronous; all CSRs clear to zero.
module marker_corner_pair_projector (
   input  logic                                 clock,
   input  logic                                 reset,
   mcpp_req_if.sink                             req,
   mcpp_rsp_if.source                           rsp,
   input  logic                                 csr_write_enable,
   input  logic [mcpp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mcpp_pkg::CSR_DATA_W-1:0]      csr_write_data
);
   import mcpp_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_CHK  = 3'd2;
   localparam logic [2:0] S_DX   = 3'd3;
   localparam logic [2:0] S_DXW  = 3'd4;
   localparam logic [2:0] S_DY   = 3'd5;
   localparam logic [2:0] S_DYW  = 3'd6;
   localparam logic [2:0] S_FIN  = 3'd7;

   localparam logic [4:0] STEP_XFORM_LAST = 5'd8;
   localparam logic [4:0] STEP_NORM_FIRST = 5'd9;
   localparam logic [4:0] STEP_LAST       = 5'd24;

   localparam logic signed [CAM_W-1:0]  DEPTH_ONE = CAM_W'(1) << (ROT_FRAC + COORD_FRAC_BITS);
   localparam logic signed [DIST_W-1:0] DIST_ONE  = DIST_W'(1) << NORM_FRAC;

   logic [63:0] row_x_ff, row_x_in, row_y_ff, row_y_in, row_z_ff, row_z_in;
   logic [47:0] radial_ff, radial_in;
   logic [31:0] tangential_ff, tangential_in;
   logic [63:0] focal_ff, focal_in, principal_ff, principal_in;

   logic [2:0]  state_ff, state_in;
   logic [4:0]  step_ff, step_in;
   logic        wb_ff, wb_in;
   logic        last_ff, last_in;
   logic        front_ff, front_in;
   logic        phase_ff, phase_in;
   logic        held_front_ff, held_front_in;
   logic [1:0]  out_cnt_ff, out_cnt_in;

   logic signed [COORD_W-1:0] px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic signed [CAM_W-1:0]   camx_ff, camx_in, camy_ff, camy_in, camz_ff, camz_in;
   logic signed [NORM_W-1:0]  x_ff, x_in, y_ff, y_in;
   logic signed [SQ_W-1:0]    xy_ff, xy_in, x2_ff, x2_in, y2_ff, y2_in;
   logic signed [R4_W-1:0]    r4_ff, r4_in;
   logic signed [R6_W-1:0]    r6_ff, r6_in;
   logic signed [DIST_W-1:0]  dist_ff, dist_in;
   logic signed [DIS_W-1:0]   xd_ff, xd_in, yd_ff, yd_in;
   logic signed [PIX_W-1:0]   u_ff, u_in, v_ff, v_in;
   logic signed [PIX_W-1:0]   held_u_ff, held_u_in, held_v_ff, held_v_in;
   logic signed [PIX_W-1:0]   o1u_ff, o1u_in, o1v_ff, o1v_in, o2u_ff, o2u_in, o2v_ff, o2v_in;

   logic signed [MA_W-1:0]    mul_a;
   logic signed [MB_W-1:0]    mul_b;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [PROD_W-1:0]  p20, p12;
   logic signed [R2_W-1:0]    r2;
   logic signed [TAN_W-1:0]   tan_x, tan_y;
   logic signed [15:0]        k1, k2, k3, p1, p2;
   logic                      div_start;
   logic signed [CAM_W-1:0]   div_num;
   mcpp_div_status_type       div_stat;
   logic                      req_take, rsp_take;

   mcpp_mul u_mul (
      .clock   (clock),
      .a       (mul_a),
      .b       (mul_b),
      .prod_ff (prod_ff)
   );

   mcpp_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (div_num),
      .den    (camz_ff),
      .status (div_stat)
   );

   assign k1 = $signed(radial_ff[15:0]);
   assign k2 = $signed(radial_ff[31:16]);
   assign k3 = $signed(radial_ff[47:32]);
   assign p1 = $signed(tangential_ff[15:0]);
   assign p2 = $signed(tangential_ff[31:16]);

   assign r2    = R2_W'(x2_ff) + R2_W'(y2_ff);
   assign tan_x = TAN_W'(r2) + (TAN_W'(x2_ff) <<< 1);
   assign tan_y = TAN_W'(r2) + (TAN_W'(y2_ff) <<< 1);
   assign p20   = prod_ff >>> NORM_FRAC;
   assign p12   = prod_ff >>> COEF_FRAC;

   assign div_start = (state_ff == S_DX) || (state_ff == S_DY);
   assign div_num   = (state_ff == S_DX) ? camx_ff : camy_ff;

   assign req.ready    = (state_ff == S_IDLE);
   assign req_take     = req.valid && req.ready;
   assign rsp.valid    = (out_cnt_ff != 2'd0);
   assign rsp_take     = rsp.valid && rsp.ready;
   assign rsp.pixel_u  = (out_cnt_ff == 2'd2) ? o1u_ff : o2u_ff;
   assign rsp.pixel_v  = (out_cnt_ff == 2'd2) ? o1v_ff : o2v_ff;
   assign rsp.last_of_pair = (out_cnt_ff == 2'd1);

   // operand select for each micro step
   always_comb begin
      case (step_ff)
         5'd0:    begin mul_a = MA_W'(px_ff); mul_b = MB_W'($signed(row_x_ff[15:0])); end
         5'd1:    begin mul_a = MA_W'(py_ff); mul_b = MB_W'($signed(row_x_ff[31:16])); end
         5'd2:    begin mul_a = MA_W'(pz_ff); mul_b = MB_W'($signed(row_x_ff[47:32])); end
         5'd3:    begin mul_a = MA_W'(px_ff); mul_b = MB_W'($signed(row_y_ff[15:0])); end
         5'd4:    begin mul_a = MA_W'(py_ff); mul_b = MB_W'($signed(row_y_ff[31:16])); end
         5'd5:    begin mul_a = MA_W'(pz_ff); mul_b = MB_W'($signed(row_y_ff[47:32])); end
         5'd6:    begin mul_a = MA_W'(px_ff); mul_b = MB_W'($signed(row_z_ff[15:0])); end
         5'd7:    begin mul_a = MA_W'(py_ff); mul_b = MB_W'($signed(row_z_ff[31:16])); end
         5'd8:    begin mul_a = MA_W'(pz_ff); mul_b = MB_W'($signed(row_z_ff[47:32])); end
         5'd9:    begin mul_a = MA_W'(x_ff);    mul_b = MB_W'(y_ff); end
         5'd10:   begin mul_a = MA_W'(x_ff);    mul_b = MB_W'(x_ff); end
         5'd11:   begin mul_a = MA_W'(y_ff);    mul_b = MB_W'(y_ff); end
         5'd12:   begin mul_a = MA_W'(r2);      mul_b = MB_W'(r2); end
         5'd13:   begin mul_a = MA_W'(r4_ff);   mul_b = MB_W'(r2); end
         5'd14:   begin mul_a = MA_W'(r2);      mul_b = MB_W'(k1); end
         5'd15:   begin mul_a = MA_W'(r4_ff);   mul_b = MB_W'(k2); end
         5'd16:   begin mul_a = MA_W'(r6_ff);   mul_b = MB_W'(k3); end
         5'd17:   begin mul_a = MA_W'(dist_ff); mul_b = MB_W'(x_ff); end
         5'd18:   begin mul_a = MA_W'(xy_ff);   mul_b = MB_W'(p1) <<< 1; end
         5'd19:   begin mul_a = MA_W'(tan_x);   mul_b = MB_W'(p2); end
         5'd20:   begin mul_a = MA_W'(dist_ff); mul_b = MB_W'(y_ff); end
         5'd21:   begin mul_a = MA_W'(xy_ff);   mul_b = MB_W'(p2) <<< 1; end
         5'd22:   begin mul_a = MA_W'(tan_y);   mul_b = MB_W'(p1); end
         5'd23:   begin
            mul_a = MA_W'($signed({1'b0, focal_ff[31:0]}));
            mul_b = MB_W'(clamp_dis(xd_ff));
         end
         5'd24:   begin
            mul_a = MA_W'($signed({1'b0, focal_ff[63:32]}));
            mul_b = MB_W'(clamp_dis(yd_ff));
         end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   always_comb begin
      row_x_in      = row_x_ff;
      row_y_in      = row_y_ff;
      row_z_in      = row_z_ff;
      radial_in     = radial_ff;
      tangential_in = tangential_ff;
      focal_in      = focal_ff;
      principal_in  = principal_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_ROW_X:      row_x_in      = csr_write_data;
            CSR_ROW_Y:      row_y_in      = csr_write_data;
            CSR_ROW_Z:      row_z_in      = csr_write_data;
            CSR_RADIAL:     radial_in     = csr_write_data[47:0];
            CSR_TANGENTIAL: tangential_in = csr_write_data[31:0];
            CSR_FOCAL:      focal_in      = csr_write_data;
            CSR_PRINCIPAL:  principal_in  = csr_write_data;
            default:        ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      wb_in         = wb_ff;
      last_in       = last_ff;
      front_in      = front_ff;
      phase_in      = phase_ff;
      held_front_in = held_front_ff;
      out_cnt_in    = out_cnt_ff;
      px_in = px_ff;  py_in = py_ff;  pz_in = pz_ff;
      camx_in = camx_ff;  camy_in = camy_ff;  camz_in = camz_ff;
      x_in = x_ff;  y_in = y_ff;
      xy_in = xy_ff;  x2_in = x2_ff;  y2_in = y2_ff;
      r4_in = r4_ff;  r6_in = r6_ff;  dist_in = dist_ff;
      xd_in = xd_ff;  yd_in = yd_ff;
      u_in = u_ff;  v_in = v_ff;
      held_u_in = held_u_ff;  held_v_in = held_v_ff;
      o1u_in = o1u_ff;  o1v_in = o1v_ff;  o2u_in = o2u_ff;  o2v_in = o2v_ff;

      if (rsp_take) out_cnt_in = out_cnt_ff - 2'd1;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               px_in   = req.point_x;
               py_in   = req.point_y;
               pz_in   = req.point_z;
               last_in = req.end_of_set;
               camx_in = CAM_W'($signed(row_x_ff[63:48])) <<< (6 + COORD_FRAC_BITS);
               camy_in = CAM_W'($signed(row_y_ff[63:48])) <<< (6 + COORD_FRAC_BITS);
               camz_in = CAM_W'($signed(row_z_ff[63:48])) <<< (6 + COORD_FRAC_BITS);
               dist_in = DIST_ONE;
               step_in = '0;
               wb_in   = 1'b0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            if (!wb_ff) begin
               wb_in = 1'b1;
            end else begin
               wb_in   = 1'b0;
               step_in = step_ff + 5'd1;
               case (step_ff)
                  5'd0, 5'd1, 5'd2: camx_in = camx_ff + prod_ff[CAM_W-1:0];
                  5'd3, 5'd4, 5'd5: camy_in = camy_ff + prod_ff[CAM_W-1:0];
                  5'd6, 5'd7, 5'd8: camz_in = camz_ff + prod_ff[CAM_W-1:0];
                  5'd9:             xy_in   = p20[SQ_W-1:0];
                  5'd10:            x2_in   = p20[SQ_W-1:0];
                  5'd11:            y2_in   = p20[SQ_W-1:0];
                  5'd12:            r4_in   = p20[R4_W-1:0];
                  5'd13:            r6_in   = p20[R6_W-1:0];
                  5'd14, 5'd15, 5'd16: dist_in = dist_ff + p12[DIST_W-1:0];
                  5'd17:            xd_in   = p20[DIS_W-1:0];
                  5'd18, 5'd19:     xd_in   = xd_ff + p12[DIS_W-1:0];
                  5'd20:            yd_in   = p20[DIS_W-1:0];
                  5'd21, 5'd22:     yd_in   = yd_ff + p12[DIS_W-1:0];
                  5'd23: u_in = sat_pix(p20 + PROD_W'($signed(principal_ff[31:0])));
                  5'd24: v_in = sat_pix(p20 + PROD_W'($signed(principal_ff[63:32])));
                  default: ;
               endcase
               if (step_ff == STEP_XFORM_LAST) state_in = S_CHK;
               if (step_ff == STEP_LAST)       state_in = S_FIN;
            end
         end
         S_CHK: begin
            if (camz_ff > DEPTH_ONE) begin
               front_in = 1'b1;
               state_in = S_DX;
            end else begin
               front_in = 1'b0;
               u_in     = '0;
               v_in     = '0;
               state_in = S_FIN;
            end
         end
         S_DX:  state_in = S_DXW;
         S_DXW: begin
            if (div_stat.done) begin
               x_in     = div_stat.quot;
               state_in = S_DY;
            end
         end
         S_DY:  state_in = S_DYW;
         S_DYW: begin
            if (div_stat.done) begin
               y_in     = div_stat.quot;
               step_in  = STEP_NORM_FIRST;
               wb_in    = 1'b0;
               state_in = S_MUL;
            end
         end
         S_FIN: begin
            if (out_cnt_ff == 2'd0) begin
               state_in = S_IDLE;
               if (!phase_ff) begin
                  if (!last_ff) begin
                     held_u_in     = u_ff;
                     held_v_in     = v_ff;
                     held_front_in = front_ff;
                     phase_in      = 1'b1;
                  end
               end else begin
                  phase_in = 1'b0;
                  if (held_front_ff && front_ff) begin
                     o1u_in     = held_u_ff;
                     o1v_in     = held_v_ff;
                     o2u_in     = u_ff;
                     o2v_in     = v_ff;
                     out_cnt_in = 2'd2;
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_x_ff      <= '0;
         row_y_ff      <= '0;
         row_z_ff      <= '0;
         radial_ff     <= '0;
         tangential_ff <= '0;
         focal_ff      <= '0;
         principal_ff  <= '0;
         state_ff      <= S_IDLE;
         step_ff       <= '0;
         wb_ff         <= 1'b0;
         phase_ff      <= 1'b0;
         held_front_ff <= 1'b0;
         held_u_ff     <= '0;
         held_v_ff     <= '0;
         out_cnt_ff    <= '0;
      end else begin
         row_x_ff      <= row_x_in;
         row_y_ff      <= row_y_in;
         row_z_ff      <= row_z_in;
         radial_ff     <= radial_in;
         tangential_ff <= tangential_in;
         focal_ff      <= focal_in;
         principal_ff  <= principal_in;
         state_ff      <= state_in;
         step_ff       <= step_in;
         wb_ff         <= wb_in;
         phase_ff      <= phase_in;
         held_front_ff <= held_front_in;
         held_u_ff     <= held_u_in;
         held_v_ff     <= held_v_in;
         out_cnt_ff    <= out_cnt_in;
      end
      last_ff  <= last_in;
      front_ff <= front_in;
      px_ff <= px_in;  py_ff <= py_in;  pz_ff <= pz_in;
      camx_ff <= camx_in;  camy_ff <= camy_in;  camz_ff <= camz_in;
      x_ff <= x_in;  y_ff <= y_in;
      xy_ff <= xy_in;  x2_ff <= x2_in;  y2_ff <= y2_in;
      r4_ff <= r4_in;  r6_ff <= r6_in;  dist_ff <= dist_in;
      xd_ff <= xd_in;  yd_ff <= yd_in;
      u_ff <= u_in;  v_ff <= v_in;
      o1u_ff <= o1u_in;  o1v_ff <= o1v_in;  o2u_ff <= o2u_in;  o2v_ff <= o2v_in;
   end

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req.ready)
      else $error("item taken but block still ready");

   a_out_cnt_range: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff != 2'd3)
      else $error("output buffer count out of range");

   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == S_DXW || state_ff == S_DYW))
      else $error("divider finished outside a divide wait");

   a_pair_second_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && !rsp.last_of_pair) |=> (rsp.valid && rsp.last_of_pair))
      else $error("second item of pair missing");
endmodule
